FILE: design/bcmq_pkg.sv
// Shared types, sizes and helper functions of the broadcast multi-queue permit block.
package bcmq_pkg;

    localparam int NUM_QUEUES  = 64;
    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_PEERS   = 1024;

    localparam int PEER_W   = 10;
    localparam int QIDX_W   = 6;
    localparam int PERMIT_W = 11;

    localparam int QSEL_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int HEAD_W  = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_ENQUEUE = 2'd0,
        MODE_CLEAR   = 2'd1,
        MODE_NEXT    = 2'd2,
        MODE_READ    = 2'd3
    } mode_t;

    typedef logic [PEER_W-1:0]          peer_t;
    typedef logic [QIDX_W-1:0]          qidx_t;
    typedef logic signed [PERMIT_W-1:0] permit_t;

    localparam permit_t NO_PERMIT = permit_t'(-1);

    typedef struct packed {
        mode_t mode;
        peer_t peer;
        qidx_t queue_index;
    } req_t;

    typedef struct packed {
        permit_t permit_peer;
        logic    dropped;
    } rsp_t;

    typedef struct packed {
        logic  push;
        logic  clear;
        logic  pop;
        peer_t peer;
    } lane_cmd_t;

    typedef struct packed {
        logic    full;
        permit_t permit;
    } lane_stat_t;

    function automatic logic peer_in_range(peer_t p);
        return {{(32-PEER_W){1'b0}}, p} < 32'(MAX_PEERS);
    endfunction

    function automatic logic index_in_range(qidx_t q);
        return {{(32-QIDX_W){1'b0}}, q} < 32'(NUM_QUEUES);
    endfunction

endpackage

FILE: design/bcmq_lane.sv
// One queue lane: ring storage, head and count pointers, and the permit register.
module bcmq_lane
    import bcmq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  lane_cmd_t  cmd,
    output lane_stat_t stat
);

    localparam int SUM_W = COUNT_W + 1;

    peer_t                store_reg [QUEUE_DEPTH];
    logic [HEAD_W-1:0]    head_reg;
    logic [HEAD_W-1:0]    head_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    permit_t              permit_reg;
    permit_t              permit_next;
    logic                 full;
    logic                 wr_en;
    logic [SUM_W-1:0]     tail_sum;
    logic [HEAD_W-1:0]    tail;
    logic [HEAD_W-1:0]    head_inc;

    assign full     = (count_reg == COUNT_W'(QUEUE_DEPTH));
    assign tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH))
                    ? HEAD_W'(tail_sum - SUM_W'(QUEUE_DEPTH))
                    : HEAD_W'(tail_sum);
    assign head_inc = (head_reg == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    always_comb begin
        head_next   = head_reg;
        count_next  = count_reg;
        permit_next = permit_reg;
        wr_en       = 1'b0;
        if (cmd.clear) begin
            head_next  = '0;
            count_next = '0;
        end else if (cmd.push) begin
            if (!full) begin
                wr_en      = 1'b1;
                count_next = count_reg + 1'b1;
            end
        end else if (cmd.pop) begin
            if (count_reg != '0) begin
                permit_next = signed'({1'b0, store_reg[head_reg]});
                head_next   = head_inc;
                count_next  = count_reg - 1'b1;
            end else begin
                permit_next = NO_PERMIT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            count_reg  <= '0;
            permit_reg <= NO_PERMIT;
        end else begin
            head_reg   <= head_next;
            count_reg  <= count_next;
            permit_reg <= permit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_reg[tail] <= cmd.peer;
        end
    end

    assign stat.full   = full;
    assign stat.permit = permit_next;

endmodule

FILE: design/bcmq_merge.sv
// Builds one result from the lane status: permit select and the dropped flag.
module bcmq_merge
    import bcmq_pkg::*;
(
    input  req_t       req,
    input  lane_stat_t stat [NUM_QUEUES],
    output rsp_t       rsp
);

    logic              any_full;
    logic [QSEL_W-1:0] sel;

    assign sel = QSEL_W'(req.queue_index);

    always_comb begin
        any_full = 1'b0;
        for (int q = 0; q < NUM_QUEUES; q++) begin
            any_full = any_full | stat[q].full;
        end
    end

    assign rsp.permit_peer = index_in_range(req.queue_index) ? stat[sel].permit : NO_PERMIT;
    assign rsp.dropped     = (req.mode == MODE_ENQUEUE) && peer_in_range(req.peer) && any_full;

endmodule

FILE: design/broadcast_multi_queue_permit.sv
// Top level of the broadcast multi-queue permit block: request register, lanes, result register.
//
// The block keeps one FIFO of peer ranks and one permit for each of NUM_QUEUES queues.
// Requests arrive on the s_ channel (s_valid, s_ready, s_data) and each one produces
// exactly one result on the m_ channel (m_valid, m_ready, m_data), in request order.
// An enqueue request pushes its peer onto every queue at once and reports in dropped
// whether any queue was full. A clear request empties one queue, a next request pops
// the front of one queue into its permit (or -1 when empty), and a read request
// returns one permit unchanged.
//
// A request is taken into the request register; all lanes then update in parallel, while
// the result register is loaded, once that register is empty or being emptied. m_valid
// rises when the result register is loaded, so each result passes through the request
// register and the result register, and the block sustains one request per cycle while
// the receiver keeps m_ready high; the rate is set by the single pass through the lane
// update logic, since each request needs the queue state left by the one before it.
//
// Reset (aresetn low at a clock edge) empties every queue, sets every permit to -1 and
// drops any request or result in flight. When the receiver holds m_ready low, the result
// stays on m_data and one more request can still be taken into the request register;
// after that s_ready falls until the result is taken.
module broadcast_multi_queue_permit
    import bcmq_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);

    // Request register stage.
    logic in_valid_reg;
    logic in_valid_next;
    req_t in_data_reg;

    // Result register stage.
    logic out_valid_reg;
    logic out_valid_next;
    rsp_t out_data_reg;

    // The request in the request register is processed in this cycle.
    logic step;
    logic s_fire;

    logic              do_push;
    logic              do_clear;
    logic              do_pop;
    logic [QSEL_W-1:0] sel;

    lane_cmd_t  lane_cmd  [NUM_QUEUES];
    lane_stat_t lane_stat [NUM_QUEUES];
    rsp_t       rsp;

    // The request advances whenever the result register is empty or being emptied.
    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;
    assign s_fire  = s_valid && s_ready;

    assign in_valid_next  = s_fire || (in_valid_reg && !step);
    assign out_valid_next = step || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_data_reg <= s_data;
        end
        if (step) begin
            out_data_reg <= rsp;
        end
    end

    // Decode the request into lane commands. Out-of-range peers are never pushed, and
    // clear and next only act on an index that names an existing queue.
    always_comb begin
        do_push  = 1'b0;
        do_clear = 1'b0;
        do_pop   = 1'b0;
        unique case (in_data_reg.mode)
            MODE_ENQUEUE: do_push  = step && peer_in_range(in_data_reg.peer);
            MODE_CLEAR:   do_clear = step && index_in_range(in_data_reg.queue_index);
            MODE_NEXT:    do_pop   = step && index_in_range(in_data_reg.queue_index);
            MODE_READ:    ;
            default:      ;
        endcase
    end

    assign sel = QSEL_W'(in_data_reg.queue_index);

    // One lane per queue; the push is broadcast, clear and pop go to the addressed lane.
    for (genvar q = 0; q < NUM_QUEUES; q++) begin : g_lane
        assign lane_cmd[q].push  = do_push;
        assign lane_cmd[q].clear = do_clear && (sel == QSEL_W'(q));
        assign lane_cmd[q].pop   = do_pop && (sel == QSEL_W'(q));
        assign lane_cmd[q].peer  = in_data_reg.peer;

        bcmq_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (lane_cmd[q]),
            .stat    (lane_stat[q])
        );
    end

    // The result carries the addressed permit after the update and the dropped flag,
    // which sees the fill levels from before the push.
    bcmq_merge u_merge (
        .req  (in_data_reg),
        .stat (lane_stat),
        .rsp  (rsp)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

FILE: design/bcmq_checker.sv
// Port-level checks of the broadcast multi-queue permit block and their binding.
module bcmq_checker
    import bcmq_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input req_t s_data,
    input logic m_valid,
    input logic m_ready,
    input rsp_t m_data
);

    // A stalled result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // Requests are refused only when a result is waiting on a stalled receiver.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("s_ready low without a stalled result");

    // Nothing is presented right after reset.
    assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_valid)
        else $error("result presented right after reset");

    // A permit is either none or a real peer rank.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.permit_peer >= NO_PERMIT)
        else $error("permit below minus one");

endmodule

bind broadcast_multi_queue_permit bcmq_checker u_bcmq_checker (.*);
